>>> rtl/bzt_pkg.sv
// ----------------------------------------------------------------------------
// bzt_pkg
// shared widths, types and arithmetic helpers for the cubic bezier tessellator
// ----------------------------------------------------------------------------
package bzt_pkg;

   localparam int COORD_W   = 16;
   localparam int NCOORD    = 3;
   localparam int COEF_W    = 20;
   localparam int FRAC_W    = 16;
   localparam int T_W       = FRAC_W + 1;
   localparam int S_W       = 24;
   localparam int PROD_W    = S_W + T_W + 1;
   localparam int SUM_W     = PROD_W + 2;
   localparam int STEP_W    = 7;
   localparam int IDX_W     = 6;
   localparam int REM_W     = IDX_W + 1;
   localparam int MAX_STEPS = 64;
   localparam int MIN_STEPS = 2;
   localparam int QDEPTH    = 2;
   localparam int QP_W      = $clog2(QDEPTH);
   localparam int QCNT_W    = $clog2(QDEPTH + 1);
   localparam int DIV_CNT_W = $clog2(T_W);
   localparam int RND_HALF  = 1 << (FRAC_W - 1);
   localparam int NSTAGE    = 6;

   localparam logic [STEP_W-1:0] STEPS_RESET = STEP_W'(MAX_STEPS);

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef coord_type [NCOORD-1:0] point_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] a;
      logic signed [COEF_W-1:0] b;
      logic signed [COEF_W-1:0] c;
      coord_type                d;
   } coef_type;

   typedef coef_type [NCOORD-1:0] seg_type;

   typedef struct packed {
      logic full;
      logic valid;
   } qstat_type;

   function automatic logic signed [COEF_W-1:0] ext_coord(input coord_type v);
      return {{(COEF_W - COORD_W){v[COORD_W-1]}}, v};
   endfunction

   function automatic logic signed [S_W-1:0] ext_coef(input logic signed [COEF_W-1:0] v);
      return {{(S_W - COEF_W){v[COEF_W-1]}}, v};
   endfunction

   // signed value times unsigned q1.16 parameter
   function automatic logic signed [PROD_W-1:0] mul_t(input logic signed [S_W-1:0] s,
                                                      input logic [T_W-1:0] t);
      logic signed [T_W:0]    ts;
      logic signed [PROD_W-1:0] p;
      ts = {1'b0, t};
      p  = s * ts;
      return p;
   endfunction

   // add coefficient, round to nearest with ties up, drop the fraction
   function automatic logic signed [S_W-1:0] rnd_add(input logic signed [PROD_W-1:0] p,
                                                     input logic signed [COEF_W-1:0] cf);
      logic signed [SUM_W-1:0] cw;
      logic signed [SUM_W-1:0] sm;
      cw = {{(SUM_W - COEF_W - FRAC_W){cf[COEF_W-1]}}, cf, {FRAC_W{1'b0}}};
      sm = {{(SUM_W - PROD_W){p[PROD_W-1]}}, p} + cw + SUM_W'(RND_HALF);
      return sm[FRAC_W +: S_W];
   endfunction

   function automatic coord_type sat_coord(input logic signed [S_W-1:0] s);
      logic fits;
      fits = (s[S_W-1:COORD_W-1] == {(S_W - COORD_W + 1){1'b0}}) ||
             (s[S_W-1:COORD_W-1] == {(S_W - COORD_W + 1){1'b1}});
      if (fits) begin
         return s[COORD_W-1:0];
      end else if (s[S_W-1]) begin
         return {1'b1, {(COORD_W - 1){1'b0}}};
      end else begin
         return {1'b0, {(COORD_W - 1){1'b1}}};
      end
   endfunction

endpackage

>>> rtl/bzt_front.sv
// ----------------------------------------------------------------------------
// bzt_front
// takes control points, tracks spline phase and builds segment coefficients
// ----------------------------------------------------------------------------
module bzt_front
   import bzt_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  coord_type req_point_x,
   input  coord_type req_point_y,
   input  coord_type req_point_z,
   input  logic      req_start_curve,
   input  qstat_type qstat,
   output logic      push,
   output seg_type   push_seg
);

   typedef enum logic [1:0] {
      KIND_ANCHOR,
      KIND_DROP,
      KIND_HANDLE,
      KIND_CLOSE
   } kind_type;

   point_type      hold_ff [3];
   logic [1:0]     phase_ff;
   logic [1:0]     phase_in;
   logic           anchor_ff;
   logic           anchor_in;
   kind_type       kind;
   point_type      pt;
   logic           accept;

   assign pt = {req_point_z, req_point_y, req_point_x};

   always_comb begin
      if (req_start_curve) begin
         kind = KIND_ANCHOR;
      end else if (!anchor_ff) begin
         kind = KIND_DROP;
      end else if (phase_ff < 2'd2) begin
         kind = KIND_HANDLE;
      end else begin
         kind = KIND_CLOSE;
      end
   end

   assign req_stall = (kind == KIND_CLOSE) && qstat.full;
   assign accept    = req_valid && !req_stall;
   assign push      = accept && (kind == KIND_CLOSE);

   always_comb begin
      phase_in  = phase_ff;
      anchor_in = anchor_ff;
      if (accept) begin
         case (kind)
            KIND_ANCHOR: begin
               phase_in  = 2'd0;
               anchor_in = 1'b1;
            end
            KIND_HANDLE: begin
               phase_in = phase_ff + 2'd1;
            end
            KIND_CLOSE: begin
               phase_in = 2'd0;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_comb begin
      logic signed [COEF_W-1:0] e0;
      logic signed [COEF_W-1:0] e1;
      logic signed [COEF_W-1:0] e2;
      logic signed [COEF_W-1:0] e3;
      logic signed [COEF_W-1:0] d12;
      logic signed [COEF_W-1:0] mid;
      logic signed [COEF_W-1:0] d10;
      for (int k = 0; k < NCOORD; k++) begin
         e0  = ext_coord(hold_ff[0][k]);
         e1  = ext_coord(hold_ff[1][k]);
         e2  = ext_coord(hold_ff[2][k]);
         e3  = ext_coord(pt[k]);
         d12 = e1 - e2;
         mid = e0 - (e1 <<< 1) + e2;
         d10 = e1 - e0;
         push_seg[k].a = e3 + (d12 <<< 1) + d12 - e0;
         push_seg[k].b = (mid <<< 1) + mid;
         push_seg[k].c = (d10 <<< 1) + d10;
         push_seg[k].d = hold_ff[0][k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= 2'd0;
         anchor_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         anchor_ff <= anchor_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         case (kind)
            KIND_ANCHOR: begin
               hold_ff[0] <= pt;
            end
            KIND_HANDLE: begin
               hold_ff[phase_ff + 2'd1] <= pt;
            end
            KIND_CLOSE: begin
               hold_ff[0] <= pt;
            end
            default: begin
               hold_ff[0] <= hold_ff[0];
            end
         endcase
      end
   end

endmodule

>>> rtl/bzt_queue.sv
// ----------------------------------------------------------------------------
// bzt_queue
// short fifo of segment coefficient sets between front and back
// ----------------------------------------------------------------------------
module bzt_queue
   import bzt_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  seg_type   push_seg,
   input  logic      pop,
   output seg_type   head,
   output qstat_type qstat
);

   seg_type            mem_ff [QDEPTH];
   logic [QP_W-1:0]    wr_ptr_ff;
   logic [QP_W-1:0]    rd_ptr_ff;
   logic [QCNT_W-1:0]  cnt_ff;
   logic [QCNT_W-1:0]  cnt_in;
   logic               do_push;
   logic               do_pop;

   assign qstat.full  = (cnt_ff == QCNT_W'(QDEPTH));
   assign qstat.valid = (cnt_ff != '0);
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && qstat.valid;
   assign head        = mem_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QP_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_seg;
      end
   end

   assert property (@(posedge clock) disable iff (reset) !(push && qstat.full))
      else $error("segment pushed into a full queue");

   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (rd_ptr_ff == wr_ptr_ff))
      else $error("queue pointers disagree while empty");

endmodule

>>> rtl/bzt_back.sv
// ----------------------------------------------------------------------------
// bzt_back
// step constant divider, parameter sequencer and horner evaluation pipeline
// ----------------------------------------------------------------------------
module bzt_back
   import bzt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             cfg_write,
   input  logic [IDX_W-1:0] den,
   input  qstat_type        qstat,
   input  seg_type          head,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output coord_type        rsp_curve_x,
   output coord_type        rsp_curve_y,
   output coord_type        rsp_curve_z,
   output logic [IDX_W-1:0] rsp_step_index,
   output logic             rsp_segment_done
);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type              state_ff;
   state_type              state_in;

   // 65536 / den, one quotient bit per cycle
   logic                   div_busy_ff;
   logic [DIV_CNT_W-1:0]   div_cnt_ff;
   logic [REM_W-1:0]       div_rem_ff;
   logic [REM_W-1:0]       div_rem_in;
   logic [T_W-1:0]         div_quo_ff;
   logic [T_W-1:0]         div_quo_in;
   logic [REM_W-1:0]       rem_sh;
   logic                   rem_ge;

   logic [IDX_W-1:0]       seg_den_ff;
   logic [IDX_W-1:0]       j_ff;
   logic [T_W-1:0]         tq_ff;
   logic [T_W-1:0]         tq_in;
   logic [IDX_W-1:0]       tr_ff;
   logic [IDX_W-1:0]       tr_in;
   logic [REM_W-1:0]       r_sum;
   logic                   r_carry;
   seg_type                coef_ff;

   logic                   en;
   logic                   start;
   logic                   issue;
   logic                   issue_last;

   logic                   sv_ff [NSTAGE];
   logic [IDX_W-1:0]       sj_ff [NSTAGE];
   logic                   sl_ff [NSTAGE];
   logic [T_W-1:0]         st_ff [NSTAGE-1];
   logic                   pipe_busy;

   logic signed [PROD_W-1:0] m1_ff [NCOORD];
   logic signed [PROD_W-1:0] m1_in [NCOORD];
   logic signed [S_W-1:0]    s1_ff [NCOORD];
   logic signed [S_W-1:0]    s1_in [NCOORD];
   logic signed [PROD_W-1:0] m2_ff [NCOORD];
   logic signed [PROD_W-1:0] m2_in [NCOORD];
   logic signed [S_W-1:0]    s2_ff [NCOORD];
   logic signed [S_W-1:0]    s2_in [NCOORD];
   logic signed [PROD_W-1:0] m3_ff [NCOORD];
   logic signed [PROD_W-1:0] m3_in [NCOORD];
   coord_type                out_in [NCOORD];

   logic                   rsp_valid_ff;
   coord_type              rsp_coord_ff [NCOORD];
   logic [IDX_W-1:0]       rsp_idx_ff;
   logic                   rsp_done_ff;

   assign en = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      pipe_busy = 1'b0;
      for (int i = 0; i < NSTAGE; i++) begin
         pipe_busy = pipe_busy | sv_ff[i];
      end
   end

   assign start      = (state_ff == ST_IDLE) && qstat.valid && !div_busy_ff && !pipe_busy;
   assign pop        = start;
   assign issue      = (state_ff == ST_RUN) && en;
   assign issue_last = (j_ff == seg_den_ff);

   always_comb begin
      rem_sh     = {div_rem_ff[REM_W-2:0], (div_cnt_ff == '0)};
      rem_ge     = (rem_sh >= {1'b0, den});
      div_rem_in = rem_ge ? (rem_sh - {1'b0, den}) : rem_sh;
      div_quo_in = {div_quo_ff[T_W-2:0], rem_ge};
   end

   always_comb begin
      r_sum   = {1'b0, tr_ff} + div_rem_ff;
      r_carry = (r_sum >= {1'b0, seg_den_ff});
      tr_in   = r_carry ? IDX_W'(r_sum - {1'b0, seg_den_ff}) : r_sum[IDX_W-1:0];
      tq_in   = tq_ff + div_quo_ff + T_W'(r_carry);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (issue && issue_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_busy_ff  <= 1'b1;
         div_cnt_ff   <= '0;
         div_rem_ff   <= '0;
         div_quo_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NSTAGE; i++) begin
            sv_ff[i] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         if (cfg_write) begin
            div_busy_ff <= 1'b1;
            div_cnt_ff  <= '0;
            div_rem_ff  <= '0;
            div_quo_ff  <= '0;
         end else if (div_busy_ff) begin
            div_rem_ff <= div_rem_in;
            div_quo_ff <= div_quo_in;
            div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_CNT_W'(T_W - 1)) begin
               div_busy_ff <= 1'b0;
            end
         end
         if (en) begin
            sv_ff[0] <= issue;
            for (int i = 1; i < NSTAGE; i++) begin
               sv_ff[i] <= sv_ff[i-1];
            end
            rsp_valid_ff <= sv_ff[NSTAGE-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         coef_ff    <= head;
         seg_den_ff <= den;
         j_ff       <= '0;
         tq_ff      <= '0;
         tr_ff      <= den >> 1;
      end else if (issue) begin
         j_ff  <= j_ff + IDX_W'(1);
         tq_ff <= tq_in;
         tr_ff <= tr_in;
      end
   end

   always_comb begin
      for (int k = 0; k < NCOORD; k++) begin
         m1_in[k]  = mul_t(ext_coef(coef_ff[k].a), st_ff[0]);
         s1_in[k]  = rnd_add(m1_ff[k], coef_ff[k].b);
         m2_in[k]  = mul_t(s1_ff[k], st_ff[2]);
         s2_in[k]  = rnd_add(m2_ff[k], coef_ff[k].c);
         m3_in[k]  = mul_t(s2_ff[k], st_ff[4]);
         out_in[k] = sat_coord(rnd_add(m3_ff[k], ext_coord(coef_ff[k].d)));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0] <= tq_ff;
         sj_ff[0] <= j_ff;
         sl_ff[0] <= issue_last;
         for (int i = 1; i < NSTAGE; i++) begin
            sj_ff[i] <= sj_ff[i-1];
            sl_ff[i] <= sl_ff[i-1];
         end
         for (int i = 1; i < NSTAGE - 1; i++) begin
            st_ff[i] <= st_ff[i-1];
         end
         for (int k = 0; k < NCOORD; k++) begin
            m1_ff[k]        <= m1_in[k];
            s1_ff[k]        <= s1_in[k];
            m2_ff[k]        <= m2_in[k];
            s2_ff[k]        <= s2_in[k];
            m3_ff[k]        <= m3_in[k];
            rsp_coord_ff[k] <= out_in[k];
         end
         rsp_idx_ff  <= sj_ff[NSTAGE-1];
         rsp_done_ff <= sl_ff[NSTAGE-1];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_curve_x      = rsp_coord_ff[0];
   assign rsp_curve_y      = rsp_coord_ff[1];
   assign rsp_curve_z      = rsp_coord_ff[2];
   assign rsp_step_index   = rsp_idx_ff;
   assign rsp_segment_done = rsp_done_ff;

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(sv_ff[NSTAGE-1]))
      else $error("result appeared without a finished pipeline transaction");

   assert property (@(posedge clock) disable iff (reset)
      (sv_ff[0] && sl_ff[0]) |-> (state_ff == ST_IDLE))
      else $error("sequencer still running after last step issued");

endmodule

>>> rtl/cubic_bezier_tessellator.sv
// ----------------------------------------------------------------------------
// cubic_bezier_tessellator
// uniform tessellation of a piecewise cubic bezier spline in fixed point
// ----------------------------------------------------------------------------
// control points enter on the req_ channel (valid/stall), one transaction per
// point; start_curve marks the first anchor of a curve. every anchor that
// closes a segment yields n = steps_per_segment (clamped to 2..64) points on
// the rsp_ channel (valid/stall), step_index 0..n-1, segment_done on the last.
// the csr_ channel writes steps_per_segment (reset 64); after reset and after
// each write a divider derives the step constants before a segment can start.
// once a segment starts its points leave one per cycle while rsp_ is not
// stalled; the next segment starts when the 6-stage horner pipeline has
// drained, so segment throughput is set by the single shared evaluation
// pipeline. points that open a segment or add handles are never stalled.
// a two-entry segment queue lets the front keep taking points while results
// are stalled; the front stalls only when a closing anchor meets a full
// queue. a stalled rsp_ freezes the pipeline.
// reset clears the phase tracking, the queue and the pipeline.
// ----------------------------------------------------------------------------
module cubic_bezier_tessellator
   import bzt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  coord_type         req_point_x,
   input  coord_type         req_point_y,
   input  coord_type         req_point_z,
   input  logic              req_start_curve,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output coord_type         rsp_curve_x,
   output coord_type         rsp_curve_y,
   output coord_type         rsp_curve_z,
   output logic [IDX_W-1:0]  rsp_step_index,
   output logic              rsp_segment_done,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [STEP_W-1:0] csr_steps_per_segment
);

   logic [STEP_W-1:0] steps_ff;
   logic [STEP_W-1:0] steps_n;
   logic [STEP_W-1:0] den_w;
   logic [IDX_W-1:0]  den;
   logic              cfg_write;
   logic              push;
   logic              pop;
   seg_type           push_seg;
   seg_type           head;
   qstat_type         qstat;

   assign csr_ready = 1'b1;
   assign cfg_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= STEPS_RESET;
      end else if (cfg_write) begin
         steps_ff <= csr_steps_per_segment;
      end
   end

   always_comb begin
      if (steps_ff < STEP_W'(MIN_STEPS)) begin
         steps_n = STEP_W'(MIN_STEPS);
      end else if (steps_ff > STEP_W'(MAX_STEPS)) begin
         steps_n = STEP_W'(MAX_STEPS);
      end else begin
         steps_n = steps_ff;
      end
      den_w = steps_n - STEP_W'(1);
      den   = den_w[IDX_W-1:0];
   end

   bzt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_point_z     (req_point_z),
      .req_start_curve (req_start_curve),
      .qstat           (qstat),
      .push            (push),
      .push_seg        (push_seg)
   );

   bzt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_seg (push_seg),
      .pop      (pop),
      .head     (head),
      .qstat    (qstat)
   );

   bzt_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg_write        (cfg_write),
      .den              (den),
      .qstat            (qstat),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_curve_x      (rsp_curve_x),
      .rsp_curve_y      (rsp_curve_y),
      .rsp_curve_z      (rsp_curve_z),
      .rsp_step_index   (rsp_step_index),
      .rsp_segment_done (rsp_segment_done)
   );

endmodule

>>> test/cubic_bezier_tessellator_test.sv
// ----------------------------------------------------------------------------
// cubic_bezier_tessellator_test
// self-checking bench for the cubic bezier tessellator
// ----------------------------------------------------------------------------
// control points go in on req_ and tessellated points come back on rsp_. a
// fixed-point model of the spline in this bench predicts each point of every
// closed segment, and each rsp_ transaction is checked against the oldest
// prediction. the run covers directed corner points, every steps setting
// class, a long result hold-off that fills the block, and random splines,
// with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module cubic_bezier_tessellator_test;
   import bzt_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 40;
   localparam longint COORD_MAX  = (64'sd1 <<< (COORD_W - 1)) - 1;
   localparam longint COORD_MIN  = -COORD_MAX - 1;

   typedef struct {
      point_type        pos;
      logic [IDX_W-1:0] index;
      logic             done;
   } curve_point_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   coord_type         req_point_x = '0;
   coord_type         req_point_y = '0;
   coord_type         req_point_z = '0;
   logic              req_start_curve = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   coord_type         rsp_curve_x;
   coord_type         rsp_curve_y;
   coord_type         rsp_curve_z;
   logic [IDX_W-1:0]  rsp_step_index;
   logic              rsp_segment_done;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [STEP_W-1:0] csr_steps_per_segment = '0;

   curve_point_type pending_points[$];
   int           mismatch_count = 0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   int           hold_request = 0;
   int           hold_left = 0;
   int           quiet_cycles = 0;

   point_type         anchor_pt;
   point_type         handle1_pt;
   point_type         handle2_pt;
   int                handles_held = 0;
   logic              anchor_held = 1'b0;
   logic [STEP_W-1:0] steps_reg = STEPS_RESET;

   cubic_bezier_tessellator uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_point_x           (req_point_x),
      .req_point_y           (req_point_y),
      .req_point_z           (req_point_z),
      .req_start_curve       (req_start_curve),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_curve_x           (rsp_curve_x),
      .rsp_curve_y           (rsp_curve_y),
      .rsp_curve_z           (rsp_curve_z),
      .rsp_step_index        (rsp_step_index),
      .rsp_segment_done      (rsp_segment_done),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_steps_per_segment (csr_steps_per_segment)
   );

   always #10 clock = ~clock;

   function automatic longint round_q16(input longint v);
      return (v + 64'sd32768) >>> 16;
   endfunction

   function automatic coord_type saturate_coord(input longint v);
      if (v > COORD_MAX) begin
         return coord_type'(COORD_MAX);
      end else if (v < COORD_MIN) begin
         return coord_type'(COORD_MIN);
      end
      return coord_type'(v);
   endfunction

   // emits the predicted points of the segment closed by p3
   task automatic tessellate_segment(input point_type p3);
      longint q0, q1, q2, q3, ca, cb, cc, s, t, den;
      int n;
      curve_point_type cp;
      n = steps_reg;
      if (n < MIN_STEPS) n = MIN_STEPS;
      if (n > MAX_STEPS) n = MAX_STEPS;
      den = n - 1;
      for (int j = 0; j < n; j++) begin
         t = (longint'(j) * 65536 + den / 2) / den;
         for (int k = 0; k < NCOORD; k++) begin
            q0 = longint'(signed'(anchor_pt[k]));
            q1 = longint'(signed'(handle1_pt[k]));
            q2 = longint'(signed'(handle2_pt[k]));
            q3 = longint'(signed'(p3[k]));
            ca = q3 + 3 * (q1 - q2) - q0;
            cb = 3 * (q0 - 2 * q1 + q2);
            cc = 3 * (q1 - q0);
            s = round_q16(ca * t + cb * 65536);
            s = round_q16(s * t + cc * 65536);
            s = round_q16(s * t + q0 * 65536);
            cp.pos[k] = saturate_coord(s);
         end
         cp.index = IDX_W'(j);
         cp.done = (j == n - 1);
         pending_points.insert(pending_points.size(), cp);
      end
   endtask

   task automatic accept_control_point(input point_type p, input logic start);
      if (start) begin
         anchor_pt = p;
         handles_held = 0;
         anchor_held = 1'b1;
      end else if (anchor_held) begin
         if (handles_held == 0) begin
            handle1_pt = p;
            handles_held = 1;
         end else if (handles_held == 1) begin
            handle2_pt = p;
            handles_held = 2;
         end else begin
            tessellate_segment(p);
            anchor_pt = p;
            handles_held = 0;
         end
      end
   endtask

   task automatic send_point(input coord_type x, input coord_type y, input coord_type z,
                             input logic start);
      point_type p;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      req_point_z <= z;
      req_start_curve <= start;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      p[0] = x;
      p[1] = y;
      p[2] = z;
      accept_control_point(p, start);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_points.size() != 0) @(posedge clock);
   endtask

   task automatic write_steps(input logic [STEP_W-1:0] value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_steps_per_segment <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      csr_valid <= 1'b0;
      steps_reg = value;
   endtask

   function automatic coord_type rand_coord();
      case ($urandom_range(3))
         0: return coord_type'($urandom_range(65535));
         1: return coord_type'(int'($urandom_range(511)) - 256);
         2: begin
            case ($urandom_range(2))
               0: return coord_type'(COORD_MAX);
               1: return coord_type'(COORD_MIN);
               default: return '0;
            endcase
         end
         default: return coord_type'(int'($urandom_range(8191)) - 4096);
      endcase
   endfunction

   task automatic send_random_point(input logic start);
      send_point(rand_coord(), rand_coord(), rand_coord(), start);
   endtask

   // corner values at the reset setting of 64 steps
   task automatic test_directed();
      send_point(16'sd7, -16'sd7, 16'sd1, 1'b0);
      send_point(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1);
      send_point(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
      send_point(16'sh8000, 16'sh7fff, 16'sh8000, 1'b0);
      send_point(16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0);
      send_point(16'sd0, 16'sh7fff, 16'sh8000, 1'b0);
      send_point(16'sh7fff, 16'sd0, 16'sd0, 1'b0);
      send_point(16'sh8000, 16'sh8000, 16'sh7fff, 1'b0);
      // new curve with a handle still held
      send_point(16'sd100, 16'sd200, 16'sd300, 1'b0);
      send_point(-16'sd16, 16'sd32, -16'sd48, 1'b1);
      send_point(16'sd64, -16'sd64, 16'sd0, 1'b0);
      send_point(16'sd128, 16'sd128, -16'sd128, 1'b0);
      send_point(16'sd256, -16'sd1, 16'sd1, 1'b0);
      // new curve where a closing anchor would go
      send_point(16'sd0, 16'sd0, 16'sd0, 1'b0);
      send_point(16'sd0, 16'sd0, 16'sd0, 1'b0);
      send_point(16'sd1000, 16'sd2000, 16'sd3000, 1'b1);
      send_point(-16'sd1, -16'sd1, -16'sd1, 1'b0);
      send_point(16'sd1, 16'sd1, 16'sd1, 1'b0);
      send_point(16'sh7fff, 16'sh8000, 16'sd0, 1'b0);
   endtask

   task automatic test_step_sweep();
      logic [STEP_W-1:0] settings[8] = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd63, 7'd64, 7'd65, 7'd127};
      foreach (settings[i]) begin
         write_steps(settings[i]);
         send_random_point(1'b1);
         repeat (3) send_random_point(1'b0);
      end
   endtask

   task automatic test_backpressure();
      write_steps(7'd8);
      hold_request = 300;
      send_random_point(1'b1);
      repeat (18) send_random_point(1'b0);
      wait_drained();
   endtask

   task automatic test_random_curves(input int count);
      int sent;
      int chunk;
      sent = 0;
      while (sent < count) begin
         case ($urandom_range(9))
            0: write_steps(7'd64);
            1: write_steps(STEP_W'($urandom_range(65, 127)));
            2: write_steps(STEP_W'($urandom_range(0, 1)));
            default: write_steps(STEP_W'($urandom_range(2, 12)));
         endcase
         chunk = (count - sent < 30) ? count - sent : 30;
         send_random_point(1'b1);
         for (int i = 1; i < chunk; i++) begin
            send_random_point($urandom_range(99) < 5);
         end
         sent += chunk;
      end
   endtask

   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      curve_point_type cp;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_points.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected transaction: x=%0d y=%0d z=%0d j=%0d done=%0b",
                        rsp_curve_x, rsp_curve_y, rsp_curve_z, rsp_step_index,
                        rsp_segment_done);
         end else begin
            cp = pending_points.pop_front();
            if (rsp_curve_x !== cp.pos[0] || rsp_curve_y !== cp.pos[1] ||
                rsp_curve_z !== cp.pos[2] || rsp_step_index !== cp.index ||
                rsp_segment_done !== cp.done) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: expected x=%0d y=%0d z=%0d j=%0d done=%0b",
                           signed'(cp.pos[0]), signed'(cp.pos[1]), signed'(cp.pos[2]),
                           cp.index, cp.done);
                  $display("          got x=%0d y=%0d z=%0d j=%0d done=%0b",
                           rsp_curve_x, rsp_curve_y, rsp_curve_z, rsp_step_index,
                           rsp_segment_done);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall) ||
          (csr_valid && csr_ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 16;
      recv_idle_pct = 57;
      test_directed();
      test_step_sweep();
      test_random_curves(70);
      send_idle_pct = 57;
      recv_idle_pct = 16;
      test_backpressure();
      test_random_curves(70);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_curves(70);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      mismatch_count += pending_points.size();
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
